>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, sampled on clk_i, disabled while rst_ni low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ibspd_pkg.sv
// ----------------------------------------------------------------------------
// ibspd_pkg
// Shared types, pattern tables and constants of the IR beacon decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ibspd_pkg;

  localparam int unsigned BITS_PER_SYMBOL = 4;
  localparam int unsigned PAT_LEN         = 16;
  localparam int unsigned NUM_PATTERNS    = 4;
  localparam int unsigned LEAD_LEN        = 4;

  typedef logic [3:0] nib_t;

  localparam nib_t IDLE_NIBBLE = 4'hF;

  localparam logic [15:0] DELAY_RESET  = 16'd500;
  localparam logic [15:0] PERIOD_RESET = 16'd1000;

  typedef enum logic [1:0] {
    PAT_UP    = 2'd0,
    PAT_LEFT  = 2'd1,
    PAT_RIGHT = 2'd2,
    PAT_BOTH  = 2'd3
  } pat_idx_e;

  localparam nib_t PAT_TABLE [NUM_PATTERNS][PAT_LEN] = '{
    '{4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd7, 4'd7, 4'd1,
      4'd7, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15},
    '{4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd7, 4'd7, 4'd1,
      4'd1, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15},
    '{4'd15, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd7, 4'd7,
      4'd1, 4'd1, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15},
    '{4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd7, 4'd1,
      4'd1, 4'd1, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15}
  };

  localparam nib_t LEAD_IN [LEAD_LEN] = '{4'h3, 4'h1, 4'h1, 4'h1};

  // flag vector: bit 2 up, bit 1 left, bit 0 right
  localparam logic [2:0] FLAG_NONE  = 3'b000;
  localparam logic [2:0] FLAG_UP    = 3'b100;
  localparam logic [2:0] FLAG_LEFT  = 3'b010;
  localparam logic [2:0] FLAG_RIGHT = 3'b001;

  typedef enum logic {
    REG_SAMPLE_DELAY = 1'b0,
    REG_BIT_PERIOD   = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic arm;
    logic sym_valid;
    nib_t nib;
  } samp_t;

  // packed MSB first: up_seen is bit 0
  typedef struct packed {
    logic [15:0] update_count;
    logic        right_seen;
    logic        left_seen;
    logic        up_seen;
  } res_t;

  function automatic logic [15:0] reload(input logic [15:0] v);
    reload = (v == 16'd0) ? 16'd1 : v;
  endfunction

endpackage

`default_nettype wire

>>> design/ibspd_sampler.sv
// ----------------------------------------------------------------------------
// ibspd_sampler
// Edge detect, tick timer and bit shifter; emits one nibble per symbol.
// ----------------------------------------------------------------------------
`default_nettype none

module ibspd_sampler (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 step_i,
  input  wire                 pin_i,
  input  wire                 stop_i,
  input  wire [15:0]          delay_i,
  input  wire [15:0]          period_i,
  output ibspd_pkg::samp_t    samp_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WAIT,
    PH_SAMPLE
  } phase_e;

  phase_e      phase_q, phase_d;
  logic        prev_q, prev_d;
  logic [15:0] cnt_q, cnt_d;
  logic [3:0]  shift_q, shift_d;
  logic [2:0]  bits_q, bits_d;
  logic [15:0] cnt_dec;
  logic [3:0]  shift_nx;
  logic [2:0]  bits_nx;
  ibspd_pkg::samp_t samp;

  always_comb begin
    phase_d  = phase_q;
    prev_d   = pin_i;
    cnt_d    = cnt_q;
    shift_d  = shift_q;
    bits_d   = bits_q;
    samp     = '0;
    cnt_dec  = cnt_q - 16'd1;
    shift_nx = {shift_q[2:0], pin_i};
    bits_nx  = bits_q + 3'd1;
    unique case (phase_q)
      PH_IDLE: begin
        if (prev_q && !pin_i) begin
          samp.arm = 1'b1;
          shift_d  = '0;
          bits_d   = '0;
          cnt_d    = ibspd_pkg::reload(delay_i);
          phase_d  = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (cnt_dec == 16'd0) begin
          cnt_d   = ibspd_pkg::reload(period_i);
          phase_d = PH_SAMPLE;
          shift_d = {3'b000, pin_i};
          bits_d  = 3'd1;
        end else begin
          cnt_d = cnt_dec;
        end
      end
      PH_SAMPLE: begin
        if (cnt_dec == 16'd0) begin
          cnt_d   = ibspd_pkg::reload(period_i);
          shift_d = shift_nx;
          bits_d  = bits_nx;
          if (bits_nx == 3'(ibspd_pkg::BITS_PER_SYMBOL)) begin
            samp.sym_valid = 1'b1;
            samp.nib       = shift_nx;
            shift_d        = '0;
            bits_d         = '0;
            if (stop_i) begin
              phase_d = PH_IDLE;
            end
          end
        end else begin
          cnt_d = cnt_dec;
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  assign samp_o = step_i ? samp : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      prev_q  <= 1'b1;
      cnt_q   <= '0;
      shift_q <= '0;
      bits_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      bits_q  <= bits_d;
    end
  end

endmodule

`default_nettype wire

>>> design/ibspd_frame.sv
// ----------------------------------------------------------------------------
// ibspd_frame
// Symbol store, lead-in check, two-frame pattern match and status registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ibspd_frame #(
  parameter int unsigned SYMBOLS_PER_FRAME = 10
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 step_i,
  input  wire                 clear_i,
  input  wire ibspd_pkg::samp_t samp_i,
  output logic                stop_o,
  output logic                res_valid_o,
  output ibspd_pkg::res_t     res_o
);

  localparam int unsigned N     = SYMBOLS_PER_FRAME;
  localparam int unsigned DEPTH = 2 * N;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ibspd_pkg::nib_t store_q [DEPTH];
  ibspd_pkg::nib_t view    [DEPTH];

  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] pos;
  logic             lead_fail;
  logic             done;
  logic             idle1;
  logic [3:0]       m0, m1;
  logic             decided;
  logic [2:0]       new_flags;
  logic             upd;
  logic [2:0]       flags_q, flags_d;
  logic [15:0]      upd_cnt_q, upd_cnt_d;

  assign pos = cnt_q[IDX_W-1:0];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      view[i] = (i == DEPTH - 1) ? samp_i.nib : store_q[i];
    end
  end

  always_comb begin
    m0    = '1;
    m1    = '1;
    idle1 = 1'b1;
    for (int p = 0; p < ibspd_pkg::NUM_PATTERNS; p++) begin
      for (int i = 0; i < N; i++) begin
        if (view[i] != ibspd_pkg::PAT_TABLE[p][i]) begin
          m0[p] = 1'b0;
        end
        if (view[N+i] != ibspd_pkg::PAT_TABLE[p][i]) begin
          m1[p] = 1'b0;
        end
      end
    end
    for (int i = 0; i < N; i++) begin
      if (view[N+i] != ibspd_pkg::IDLE_NIBBLE) begin
        idle1 = 1'b0;
      end
    end
  end

  always_comb begin
    decided   = 1'b1;
    new_flags = ibspd_pkg::FLAG_NONE;
    if (m0[ibspd_pkg::PAT_UP]) begin
      if (idle1 || m1[ibspd_pkg::PAT_UP]) begin
        new_flags = ibspd_pkg::FLAG_UP;
      end else if (m1[ibspd_pkg::PAT_LEFT]) begin
        new_flags = ibspd_pkg::FLAG_UP | ibspd_pkg::FLAG_LEFT;
      end else if (m1[ibspd_pkg::PAT_RIGHT]) begin
        new_flags = ibspd_pkg::FLAG_UP | ibspd_pkg::FLAG_RIGHT;
      end else if (m1[ibspd_pkg::PAT_BOTH]) begin
        new_flags = ibspd_pkg::FLAG_UP | ibspd_pkg::FLAG_LEFT | ibspd_pkg::FLAG_RIGHT;
      end else begin
        new_flags = ibspd_pkg::FLAG_UP;
      end
    end else if (m0[ibspd_pkg::PAT_LEFT]) begin
      new_flags = ibspd_pkg::FLAG_LEFT;
    end else if (m0[ibspd_pkg::PAT_RIGHT]) begin
      new_flags = ibspd_pkg::FLAG_RIGHT;
    end else if (m0[ibspd_pkg::PAT_BOTH]) begin
      new_flags = ibspd_pkg::FLAG_LEFT | ibspd_pkg::FLAG_RIGHT;
    end else begin
      decided = 1'b0;
    end
  end

  assign lead_fail = samp_i.sym_valid && (cnt_q < CNT_W'(ibspd_pkg::LEAD_LEN))
                   && ((cnt_q + CNT_W'(1)) < CNT_W'(N))
                   && (samp_i.nib != ibspd_pkg::LEAD_IN[pos[1:0]]);
  assign done   = samp_i.sym_valid && (cnt_q == CNT_W'(DEPTH - 1));
  assign stop_o = lead_fail || done;
  assign upd    = done && decided;

  always_comb begin
    flags_d   = clear_i ? ibspd_pkg::FLAG_NONE : flags_q;
    upd_cnt_d = clear_i ? 16'd0 : upd_cnt_q;
    if (upd) begin
      flags_d   = new_flags;
      upd_cnt_d = upd_cnt_d + 16'd1;
    end
  end

  assign res_valid_o         = step_i && (upd || clear_i);
  assign res_o.up_seen       = flags_d[2];
  assign res_o.left_seen     = flags_d[1];
  assign res_o.right_seen    = flags_d[0];
  assign res_o.update_count  = upd_cnt_d;

  always_ff @(posedge clk_i) begin
    if (samp_i.sym_valid) begin
      store_q[pos] <= samp_i.nib;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      flags_q   <= '0;
      upd_cnt_q <= '0;
    end else if (step_i) begin
      if (samp_i.arm) begin
        cnt_q <= '0;
      end else if (samp_i.sym_valid) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      flags_q   <= flags_d;
      upd_cnt_q <= upd_cnt_d;
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(DEPTH), "symbol count beyond store depth")
  `ASSERT_NEXT(a_upd_bumps, step_i && upd && !clear_i,
               upd_cnt_q == $past(upd_cnt_q) + 16'd1, "update count did not advance")

endmodule

`default_nettype wire

>>> design/ibspd_out_fifo.sv
// ----------------------------------------------------------------------------
// ibspd_out_fifo
// Two-entry result buffer between the decoder and the master stream.
// ----------------------------------------------------------------------------
`default_nettype none

module ibspd_out_fifo (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 push_i,
  input  wire ibspd_pkg::res_t data_i,
  output logic                full_o,
  output logic                valid_o,
  input  wire                 ready_i,
  output ibspd_pkg::res_t     data_o
);

  ibspd_pkg::res_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;
  logic            pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign pop     = valid_o && ready_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

`include "assert_macros.svh"

  `ASSERT_IMPL(a_no_push_full, push_i, !full_o || pop, "push into full result buffer")
  `ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q != 2'd3, "result buffer count out of range")

endmodule

`default_nettype wire

>>> design/ir_beacon_symbol_pattern_decoder_core.sv
// ----------------------------------------------------------------------------
// ir_beacon_symbol_pattern_decoder_core
// IR beacon decoder: samples the pin per tick, collects symbols, matches
// two frames against the emitter patterns and publishes up/left/right flags.
// ----------------------------------------------------------------------------
//  channel   dir   handshake                 content
//  s_axis    in    tvalid/tready             one timer tick
//  m_axis    out   tvalid/tready             status update
//  apb       in    psel/penable/pwrite       sample delay, bit period
//
//  One tick is taken per clock while the result buffer has room; a status update
//  is held in the buffer before m_axis shows it. The per-tick step (timer, shifter,
//  2-frame compare) is combinational from the state registers to the two-entry buffer.
//  s_axis_tready drops only while both result buffer entries are held.
//  Reset is immediate; the symbol store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_beacon_symbol_pattern_decoder_core #(
  parameter int unsigned SYMBOLS_PER_FRAME = 10
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [2:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [0] pin_level, [1] clear_status
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [23:0] m_axis_tdata    // [0] up_seen, [1] left_seen, [2] right_seen,
                                      // [18:3] update_count
);

  logic [15:0]          delay_q, period_q;
  logic                 cfg_wr;
  ibspd_pkg::reg_idx_e  reg_idx;
  logic                 step;
  logic                 fifo_full;
  logic                 stop;
  logic                 res_valid;
  ibspd_pkg::samp_t     samp;
  ibspd_pkg::res_t      res, res_out;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = ibspd_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    unique case (reg_idx)
      ibspd_pkg::REG_SAMPLE_DELAY: prdata = {16'd0, delay_q};
      ibspd_pkg::REG_BIT_PERIOD:   prdata = {16'd0, period_q};
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= ibspd_pkg::DELAY_RESET;
      period_q <= ibspd_pkg::PERIOD_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ibspd_pkg::REG_SAMPLE_DELAY: delay_q  <= pwdata[15:0];
        ibspd_pkg::REG_BIT_PERIOD:   period_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !fifo_full;
  assign step          = s_axis_tvalid && s_axis_tready;

  ibspd_sampler u_sampler (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .pin_i    (s_axis_tdata[0]),
    .stop_i   (stop),
    .delay_i  (delay_q),
    .period_i (period_q),
    .samp_o   (samp)
  );

  ibspd_frame #(
    .SYMBOLS_PER_FRAME (SYMBOLS_PER_FRAME)
  ) u_frame (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .clear_i     (s_axis_tdata[1]),
    .samp_i      (samp),
    .stop_o      (stop),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ibspd_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .full_o  (fifo_full),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (res_out)
  );

  assign m_axis_tdata = {5'd0, res_out};

endmodule

`default_nettype wire
